[rtl/rpm_pkg.sv]
package rpm_pkg;

  localparam int MAX_PATTERN_DEF  = 8;
  localparam int BUFFER_DEPTH_DEF = 1024;

  localparam int PATTERN_W = 64;
  localparam int LEN_W     = 4;
  localparam int TIMEOUT_W = 16;
  localparam int INDEX_W   = 10;
  localparam int ELAPSED_W = 16;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;

  localparam logic [LEN_W-1:0]     PATTERN_LENGTH_RST = 4'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MS_RST     = 16'd5000;
  localparam logic                 STOP_ON_MATCH_RST  = 1'b1;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // register index = paddr[4:3]
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_TIMEOUT_MS     = 2'd2,
    REG_STOP_ON_MATCH  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]     pattern_length;
    logic [TIMEOUT_W-1:0] timeout_ms;
    logic                 stop_on_match;
  } cfg_t;

  typedef struct packed {
    logic               matched;
    logic [INDEX_W-1:0] match_index;
    logic               window_done;
    logic               timed_out;
  } result_t;

endpackage

[rtl/response_pattern_matcher_top.sv]
// A result is registered in the output buffer when its request is accepted.
// Throughput: one request per cycle while in_stall is low; the state update and the eight-byte
// window compare sit between the state registers and the output register.
// A two-entry output buffer takes one more request while a result is stalled;
// the input stalls once both entries are full.
// Reset (rst_n low, synchronous) opens an empty window and loads register defaults.
module response_pattern_matcher_top #(
  parameter int MAX_PATTERN  = rpm_pkg::MAX_PATTERN_DEF,
  parameter int BUFFER_DEPTH = rpm_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [7:0]                     in_rx_byte,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_matched,
  output logic [rpm_pkg::INDEX_W-1:0]    out_match_index,
  output logic                           out_window_done,
  output logic                           out_timed_out,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpm_pkg::ADDR_W-1:0]     paddr,
  input  logic [rpm_pkg::DATA_W-1:0]     pwdata,
  output logic [rpm_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  rpm_pkg::cfg_t    cfg;
  rpm_pkg::result_t result;
  rpm_pkg::result_t out_data;
  logic             accept;
  logic             full;

  assign in_stall = full;
  assign accept   = in_valid & ~full;

  rpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpm_state #(
    .MAX_PATTERN  (MAX_PATTERN),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .action  (in_action),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .result  (result)
  );

  rpm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_matched     = out_data.matched;
  assign out_match_index = out_data.match_index;
  assign out_window_done = out_data.window_done;
  assign out_timed_out   = out_data.timed_out;

  a_timeout_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timed_out) |-> (out_window_done && !out_matched))
    else $error("timed_out reported on an open or matched window");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry held while output slot is empty");

  a_stall_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_valid && out_stall) |=> in_stall)
    else $error("request accepted into a stalled output without holding it");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

endmodule

[rtl/rpm_cfg.sv]
module rpm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpm_pkg::DATA_W-1:0]  pwdata,
  output logic [rpm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rpm_pkg::cfg_t               cfg
);

  rpm_pkg::cfg_t     cfg_r;
  rpm_pkg::cfg_t     cfg_nxt;
  rpm_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = rpm_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        rpm_pkg::REG_PATTERN_BYTES:  cfg_nxt.pattern_bytes  = pwdata;
        rpm_pkg::REG_PATTERN_LENGTH: cfg_nxt.pattern_length = pwdata[rpm_pkg::LEN_W-1:0];
        rpm_pkg::REG_TIMEOUT_MS:     cfg_nxt.timeout_ms     = pwdata[rpm_pkg::TIMEOUT_W-1:0];
        rpm_pkg::REG_STOP_ON_MATCH:  cfg_nxt.stop_on_match  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes  <= '0;
      cfg_r.pattern_length <= rpm_pkg::PATTERN_LENGTH_RST;
      cfg_r.timeout_ms     <= rpm_pkg::TIMEOUT_MS_RST;
      cfg_r.stop_on_match  <= rpm_pkg::STOP_ON_MATCH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      rpm_pkg::REG_PATTERN_BYTES:  prdata = cfg_r.pattern_bytes;
      rpm_pkg::REG_PATTERN_LENGTH:
        prdata = {{(rpm_pkg::DATA_W-rpm_pkg::LEN_W){1'b0}}, cfg_r.pattern_length};
      rpm_pkg::REG_TIMEOUT_MS:
        prdata = {{(rpm_pkg::DATA_W-rpm_pkg::TIMEOUT_W){1'b0}}, cfg_r.timeout_ms};
      rpm_pkg::REG_STOP_ON_MATCH:
        prdata = {{(rpm_pkg::DATA_W-1){1'b0}}, cfg_r.stop_on_match};
      default: prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[rtl/rpm_match.sv]
module rpm_match #(
  parameter int MAX_PATTERN = rpm_pkg::MAX_PATTERN_DEF,
  parameter int CNT_W       = 11
) (
  input  logic [8*MAX_PATTERN-1:0]       window,
  input  logic [rpm_pkg::PATTERN_W-1:0]  pattern_bytes,
  input  logic [rpm_pkg::LEN_W-1:0]      pattern_length,
  input  logic [CNT_W-1:0]               count,
  output logic                           hit,
  output logic [rpm_pkg::LEN_W-1:0]      eff_len
);

  logic [rpm_pkg::LEN_W-1:0] len_clamp;
  logic                      eq_sel;

  assign len_clamp = (pattern_length > rpm_pkg::LEN_W'(MAX_PATTERN)) ?
                     rpm_pkg::LEN_W'(MAX_PATTERN) : pattern_length;

  // pattern ends before its first zero byte
  always_comb begin
    eff_len = len_clamp;
    for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
      if ((rpm_pkg::LEN_W'(i) < len_clamp) && (pattern_bytes[8*i +: 8] == 8'd0)) begin
        eff_len = rpm_pkg::LEN_W'(i);
      end
    end
  end

  // compare newest bytes against the pattern, one candidate per length
  always_comb begin
    logic eq_l;
    int   idx;
    eq_sel = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      eq_l = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        idx = (i < l) ? (l - 1 - i) : 0;
        if ((i < l) && (pattern_bytes[8*i +: 8] != window[8*idx +: 8])) begin
          eq_l = 1'b0;
        end
      end
      if (eff_len == rpm_pkg::LEN_W'(l)) begin
        eq_sel = eq_l;
      end
    end
  end

  assign hit = (eff_len != '0) &&
               (count >= {{(CNT_W-rpm_pkg::LEN_W){1'b0}}, eff_len}) && eq_sel;

endmodule

[rtl/rpm_state.sv]
module rpm_state #(
  parameter int MAX_PATTERN  = rpm_pkg::MAX_PATTERN_DEF,
  parameter int BUFFER_DEPTH = rpm_pkg::BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [7:0]        rx_byte,
  input  rpm_pkg::cfg_t     cfg,
  output rpm_pkg::result_t  result
);

  localparam int WIN_W = 8 * MAX_PATTERN;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int DIF_W = (CNT_W > rpm_pkg::INDEX_W) ? CNT_W : rpm_pkg::INDEX_W;

  logic [WIN_W-1:0]                window_r, window_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [rpm_pkg::ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic                            found_r, found_nxt;
  logic [rpm_pkg::INDEX_W-1:0]     index_r, index_nxt;
  logic                            closed_r, closed_nxt;

  logic [WIN_W+7:0]                win_ext;
  logic [WIN_W-1:0]                win_shift;
  logic [CNT_W-1:0]                count_inc;
  logic                            hit;
  logic [rpm_pkg::LEN_W-1:0]       eff_len;
  logic [DIF_W-1:0]                start_off;
  logic                            byte_take;

  assign win_ext   = {window_r, rx_byte};
  assign win_shift = win_ext[WIN_W-1:0];
  assign count_inc = count_r + 1'b1;
  assign byte_take = !closed_r && (rx_byte != 8'd0) && (count_r < CNT_W'(BUFFER_DEPTH));
  assign start_off = DIF_W'(count_inc) - DIF_W'(eff_len);

  rpm_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .CNT_W       (CNT_W)
  ) u_match (
    .window         (win_shift),
    .pattern_bytes  (cfg.pattern_bytes),
    .pattern_length (cfg.pattern_length),
    .count          (count_inc),
    .hit            (hit),
    .eff_len        (eff_len)
  );

  always_comb begin
    window_nxt  = window_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    found_nxt   = found_r;
    index_nxt   = index_r;
    closed_nxt  = closed_r;
    if (accept) begin
      case (rpm_pkg::action_t'(action))
        rpm_pkg::ACT_START: begin
          window_nxt  = '0;
          count_nxt   = '0;
          elapsed_nxt = '0;
          found_nxt   = 1'b0;
          index_nxt   = '0;
          closed_nxt  = 1'b0;
        end
        rpm_pkg::ACT_BYTE: begin
          if (byte_take) begin
            window_nxt = win_shift;
            count_nxt  = count_inc;
            if (!found_r && hit) begin
              found_nxt = 1'b1;
              index_nxt = start_off[rpm_pkg::INDEX_W-1:0];
            end
          end
        end
        rpm_pkg::ACT_TICK: begin
          if (!closed_r && (elapsed_r != rpm_pkg::ELAPSED_MAX)) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
        end
        default: ;
      endcase
      // close on timeout, or on a match when stop-on-match is set
      if (!closed_nxt &&
          ((elapsed_nxt >= cfg.timeout_ms) || (found_nxt && cfg.stop_on_match))) begin
        closed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      count_r   <= '0;
      elapsed_r <= '0;
      found_r   <= 1'b0;
      index_r   <= '0;
      closed_r  <= 1'b0;
    end else begin
      window_r  <= window_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      found_r   <= found_nxt;
      index_r   <= index_nxt;
      closed_r  <= closed_nxt;
    end
  end

  assign result.matched     = found_nxt;
  assign result.match_index = index_nxt;
  assign result.window_done = closed_nxt;
  assign result.timed_out   = closed_nxt & ~found_nxt;

endmodule

[rtl/rpm_out_buf.sv]
module rpm_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rpm_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output rpm_pkg::result_t  out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  rpm_pkg::result_t out_data_r, out_data_nxt;
  rpm_pkg::result_t skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      // output slot frees up: older skid entry goes first
      out_valid_nxt  = skid_valid_r | push;
      out_data_nxt   = skid_valid_r ? skid_data_r : push_data;
      skid_valid_nxt = skid_valid_r & push;
      skid_data_nxt  = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/tb_response_pattern_matcher_top.sv]
module tb_response_pattern_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 150;
  localparam int RANDOM_REQUESTS = 840;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_START;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_matched;
  logic [INDEX_W-1:0] out_match_index;
  logic               out_window_done;
  logic               out_timed_out;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // shadow of the block: registers and window state
  cfg_t                 shadow_cfg = {64'h0, PATTERN_LENGTH_RST, TIMEOUT_MS_RST, STOP_ON_MATCH_RST};
  logic [63:0]          win_bytes = '0;
  logic [10:0]          rx_count = '0;
  logic [ELAPSED_W-1:0] ms_elapsed = '0;
  logic                 hit_seen = 1'b0;
  logic [INDEX_W-1:0]   hit_at = '0;
  logic                 win_closed = 1'b0;

  request_t pending[$];
  result_t  status_due[$];
  request_t next_req;
  result_t  want;

  int errors = 0;
  int requests_made = 0;
  int results_seen = 0;
  int match_results = 0;
  int timeout_results = 0;
  int reg_writes = 0;
  int idle_cycles = 0;
  int idle_odds = 4;
  int send_gap = 0;
  int stall_gap = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  response_pattern_matcher_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_matched(out_matched),
    .out_match_index(out_match_index), .out_window_done(out_window_done),
    .out_timed_out(out_timed_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // pattern ends at the first zero byte
  function automatic int unsigned pattern_span();
    int unsigned len;
    int unsigned i;
    len = shadow_cfg.pattern_length;
    if (len > MAX_PATTERN_DEF) len = MAX_PATTERN_DEF;
    for (i = 0; i < len; i++)
      if (shadow_cfg.pattern_bytes[8*i +: 8] == 8'h00) return i;
    return len;
  endfunction

  function automatic bit window_hits(int unsigned len);
    int unsigned i;
    if (len == 0 || rx_count < len) return 1'b0;
    for (i = 0; i < len; i++)
      if (shadow_cfg.pattern_bytes[8*i +: 8] != win_bytes[8*(len-1-i) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic result_t track_status(logic [1:0] act, logic [7:0] rx);
    int unsigned plen;
    result_t r;
    plen = pattern_span();
    case (act)
      ACT_START: begin
        win_bytes = '0;
        rx_count = '0;
        ms_elapsed = '0;
        hit_seen = 1'b0;
        hit_at = '0;
        win_closed = 1'b0;
      end
      ACT_BYTE: begin
        if (!win_closed && rx != 8'h00 && rx_count < BUFFER_DEPTH_DEF) begin
          win_bytes = {win_bytes[55:0], rx};
          rx_count++;
          if (!hit_seen && window_hits(plen)) begin
            hit_seen = 1'b1;
            hit_at = INDEX_W'(rx_count - plen);
          end
        end
      end
      ACT_TICK: begin
        if (!win_closed && ms_elapsed != ELAPSED_MAX) ms_elapsed++;
      end
      default: ;
    endcase
    if (!win_closed && (ms_elapsed >= shadow_cfg.timeout_ms ||
                        (hit_seen && shadow_cfg.stop_on_match)))
      win_closed = 1'b1;
    r.matched = hit_seen;
    r.match_index = hit_seen ? hit_at : '0;
    r.window_done = win_closed;
    r.timed_out = win_closed && !hit_seen;
    return r;
  endfunction

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) status_due.push_back(track_status(in_action, in_rx_byte));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0 && idle_odds > 0 &&
                     $urandom_range(0, idle_odds - 1) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          next_req = pending.pop_front();
          in_action <= next_req.action;
          in_rx_byte <= next_req.rx;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (status_due.size() == 0) begin
        note_error($sformatf("unexpected result: matched=%0d index=%0d done=%0d timed_out=%0d",
                             out_matched, out_match_index, out_window_done, out_timed_out));
      end else begin
        want = status_due.pop_front();
        if (out_matched !== want.matched || out_match_index !== want.match_index ||
            out_window_done !== want.window_done || out_timed_out !== want.timed_out)
          note_error($sformatf({"result %0d: expected matched=%0d index=%0d done=%0d ",
                                "timed_out=%0d, got matched=%0d index=%0d done=%0d timed_out=%0d"},
                               results_seen, want.matched, want.match_index, want.window_done,
                               want.timed_out, out_matched, out_match_index, out_window_done,
                               out_timed_out));
        if (want.matched) match_results++;
        if (want.timed_out) timeout_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("tb_response_pattern_matcher_top: FAIL");
        $finish;
      end
    end
  end

  task automatic queue_request(logic [1:0] act, logic [7:0] rx);
    pending.push_back('{action: act, rx: rx});
    requests_made++;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending.size() != 0 || in_valid || status_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // write, then read back
  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    logic [63:0] kept;
    logic [63:0] got;
    case (idx)
      REG_PATTERN_BYTES: begin
        kept = value;
        shadow_cfg.pattern_bytes = kept;
      end
      REG_PATTERN_LENGTH: begin
        kept = {60'b0, value[LEN_W-1:0]};
        shadow_cfg.pattern_length = kept[LEN_W-1:0];
      end
      REG_TIMEOUT_MS: begin
        kept = {48'b0, value[TIMEOUT_W-1:0]};
        shadow_cfg.timeout_ms = kept[TIMEOUT_W-1:0];
      end
      default: begin
        kept = {63'b0, value[0]};
        shadow_cfg.stop_on_match = kept[0];
      end
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== kept)
      note_error($sformatf("register %s read %h, expected %h", idx.name(), got, kept));
  endtask

  task automatic shuffle_config(bit all);
    logic [63:0] pat;
    logic [63:0] v;
    int unsigned plen;
    int i;
    int zpos;
    plen = $urandom_range(1, 8);
    pat = {$urandom, $urandom};
    if ($urandom_range(0, 5) != 0) begin
      for (i = 0; i < plen; i++) pat[8*i +: 8] = 8'(8'h41 + $urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) begin
        zpos = $urandom_range(0, plen - 1);
        pat[8*zpos +: 8] = 8'h00;
      end
    end
    if (all || $urandom_range(0, 3) != 0) write_reg(REG_PATTERN_BYTES, pat);
    if (all || $urandom_range(0, 3) != 0) begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: v[3:0] = 4'd0;
        1: v[3:0] = 4'($urandom_range(9, 15));
        default: v[3:0] = 4'(plen);
      endcase
      write_reg(REG_PATTERN_LENGTH, v);
    end
    if (all || $urandom_range(0, 3) != 0) begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 11))
        0: v[15:0] = 16'd0;
        1: v[15:0] = 16'hFFFF;
        default: v[15:0] = 16'($urandom_range(1, 40));
      endcase
      write_reg(REG_TIMEOUT_MS, v);
    end
    if (all || $urandom_range(0, 3) != 0) write_reg(REG_STOP_ON_MATCH, {$urandom, $urandom});
  endtask

  // mostly pattern bytes and letters A to D, with whole pattern runs, ticks, zeros, restarts and stray actions mixed in
  task automatic traffic(int n);
    int k;
    int i;
    int pick;
    int span;
    if ($urandom_range(0, 4) != 0) queue_request(ACT_START, 8'($urandom_range(0, 255)));
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        queue_request(ACT_START, 8'($urandom_range(0, 255)));
      end else if (pick < 5) begin
        queue_request(ACT_UNUSED, 8'($urandom_range(0, 255)));
      end else if (pick < 20) begin
        queue_request(ACT_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 24) begin
        queue_request(ACT_BYTE, 8'h00);
      end else if (pick < 34) begin
        queue_request(ACT_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 46) begin
        span = shadow_cfg.pattern_length;
        if (span > MAX_PATTERN_DEF) span = MAX_PATTERN_DEF;
        for (i = 0; i < span; i++) queue_request(ACT_BYTE, shadow_cfg.pattern_bytes[8*i +: 8]);
      end else if (pick < 73) begin
        i = $urandom_range(0, 7);
        queue_request(ACT_BYTE, shadow_cfg.pattern_bytes[8*i +: 8]);
      end else begin
        queue_request(ACT_BYTE, 8'(8'h41 + $urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    int base;
    int phase;
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: empty pattern never matches
    queue_request(ACT_BYTE, 8'hFF);
    queue_request(ACT_BYTE, 8'h00);
    queue_request(ACT_UNUSED, 8'hAA);
    queue_request(ACT_TICK, 8'h55);
    drain();

    write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0043_4241);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_TIMEOUT_MS, 64'd20);
    write_reg(REG_STOP_ON_MATCH, 64'd1);
    queue_request(ACT_START, 8'h00);
    queue_request(ACT_BYTE, 8'h41);
    queue_request(ACT_BYTE, 8'h42);
    queue_request(ACT_BYTE, 8'h00);
    queue_request(ACT_BYTE, 8'h43);
    queue_request(ACT_BYTE, 8'h41);
    queue_request(ACT_TICK, 8'h00);
    queue_request(ACT_UNUSED, 8'hFF);
    drain();

    // length above the limit acts as eight, full window match at offset zero
    write_reg(REG_PATTERN_BYTES, 64'h8040_2010_0804_0201);
    write_reg(REG_PATTERN_LENGTH, 64'd15);
    write_reg(REG_TIMEOUT_MS, 64'hFFFF);
    write_reg(REG_STOP_ON_MATCH, 64'd0);
    queue_request(ACT_START, 8'h00);
    for (i = 0; i < 8; i++) queue_request(ACT_BYTE, 8'h01 << i);
    queue_request(ACT_BYTE, 8'h01);
    drain();

    // stop-on-match turned on late closes the open window on the next request
    write_reg(REG_STOP_ON_MATCH, 64'd1);
    write_reg(REG_TIMEOUT_MS, 64'd0);
    queue_request(ACT_TICK, 8'h00);
    queue_request(ACT_START, 8'h00);
    queue_request(ACT_BYTE, 8'h41);
    drain();

    base = requests_made;
    phase = 0;
    while (requests_made - base < RANDOM_REQUESTS) begin
      shuffle_config(phase == 0);
      case ($urandom_range(0, 3))
        0: idle_odds = 0;
        1: idle_odds = 3;
        2: idle_odds = 10;
        default: idle_odds = 25;
      endcase
      if (phase == 6) begin
        // hold results back while requests keep coming
        idle_odds = 0;
        hold_req = 1'b1;
        traffic(80);
      end else begin
        traffic($urandom_range(8, 40));
      end
      drain();
      phase++;
    end

    idle_odds = 0;
    shuffle_config(1'b1);
    traffic(60);
    drain();
    repeat (5) @(posedge clk);

    if (status_due.size() != 0)
      note_error($sformatf("%0d results never arrived", status_due.size()));
    $display("covered %0d requests, %0d results (%0d matched, %0d timed out), %0d register writes",
             requests_made, results_seen, match_results, timeout_results, reg_writes);
    $display("random patterns, lengths and timeouts under stalls and a long output hold, %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb_response_pattern_matcher_top: PASS");
    end else begin
      $display("tb_response_pattern_matcher_top: FAIL");
    end
    $finish;
  end

endmodule
